/* rtl/core/lswc_pkg.sv */
// Shared types and constants for the line segment window clipper.
package lswc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = COORD_W + 1;   // magnitude of a coordinate difference
  localparam int unsigned PROD_W  = 2 * MAG_W;     // full product width
  localparam int unsigned QUO_W   = COORD_W + 2;   // quotient bits resolved by the cells
  localparam int unsigned HI_W    = PROD_W - 1 - QUO_W; // product bits above the cell range
  localparam int unsigned NUM_CHECKS = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SOUTH = 2'd0;
  localparam logic [1:0] CFG_NORTH = 2'd1;
  localparam logic [1:0] CFG_WEST  = 2'd2;
  localparam logic [1:0] CFG_EAST  = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] south;
    logic signed [COORD_W-1:0] north;
    logic signed [COORD_W-1:0] west;
    logic signed [COORD_W-1:0] east;
  } win_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      modif;
  } seg_t;

  typedef struct packed {
    seg_t                      seg;
    logic signed [COORD_W-1:0] other;
    logic                      interp;
    logic                      neg;
    logic                      zero;
    logic                      ovf;
    logic [MAG_W-1:0]          md;
    logic [MAG_W-1:0]          rem;
    logic [QUO_W-1:0]          num_lo;
    logic [QUO_W-1:0]          quo;
  } div_t;

endpackage

/* rtl/core/lswc_div_cell.sv */
// One restoring-division cell: resolves a single quotient bit per cycle while enabled.
module lswc_div_cell #(
  parameter int unsigned BIT_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  lswc_pkg::div_t data_i,
  output logic          valid_o,
  output lswc_pkg::div_t data_o
);
  import lswc_pkg::*;

  logic             valid_q;
  div_t             data_q, data_d;
  logic [MAG_W:0]   trial;
  logic             ge;

  always_comb begin
    data_d = data_i;
    trial  = {data_i.rem, data_i.num_lo[BIT_IDX]};
    ge     = trial >= {1'b0, data_i.md};
    data_d.rem = ge ? MAG_W'(trial - {1'b0, data_i.md}) : trial[MAG_W-1:0];
    data_d.quo[BIT_IDX] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lswc_check.sv */
// One boundary check: compare and clamp, multiply, divider cell row, interpolate.
module lswc_check #(
  parameter int unsigned CHECK_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  lswc_pkg::win_t win_i,
  input  logic          valid_i,
  input  lswc_pkg::seg_t seg_i,
  output logic          valid_o,
  output lswc_pkg::seg_t seg_o
);
  import lswc_pkg::*;

  localparam bit IS_Y   = (CHECK_IDX >= 4);
  localparam bit IS_END = ((CHECK_IDX / 2) % 2) == 1;
  localparam bit UPPER  = (CHECK_IDX % 2) == 1;

  // Stage A: compare, clamp and set up the interpolation operands.
  logic signed [COORD_W-1:0] bound, c, far_c, other, far_other;
  logic signed [MAG_W-1:0]   a, b, d;
  logic                      fire;
  div_t                      a_d, a_q;
  logic [MAG_W-1:0]          ma_d, mb_d, ma_q, mb_q;
  logic                      a_valid_q;

  always_comb begin
    if (IS_Y) begin
      bound     = UPPER ? win_i.north : win_i.south;
      c         = IS_END ? seg_i.y1 : seg_i.y0;
      far_c     = IS_END ? seg_i.y0 : seg_i.y1;
      other     = IS_END ? seg_i.x1 : seg_i.x0;
      far_other = IS_END ? seg_i.x0 : seg_i.x1;
    end else begin
      bound     = UPPER ? win_i.east : win_i.west;
      c         = IS_END ? seg_i.x1 : seg_i.x0;
      far_c     = IS_END ? seg_i.x0 : seg_i.x1;
      other     = IS_END ? seg_i.y1 : seg_i.y0;
      far_other = IS_END ? seg_i.y0 : seg_i.y1;
    end
    fire = UPPER ? (c > bound) : (c < bound);
    a    = MAG_W'(bound) - MAG_W'(c);
    b    = MAG_W'(far_other) - MAG_W'(other);
    d    = MAG_W'(far_c) - MAG_W'(c);
    ma_d = a[MAG_W-1] ? MAG_W'(-a) : MAG_W'(a);
    mb_d = b[MAG_W-1] ? MAG_W'(-b) : MAG_W'(b);

    a_d        = '0;
    a_d.seg    = seg_i;
    a_d.other  = other;
    a_d.interp = fire && (far_c != c);
    a_d.neg    = a[MAG_W-1] ^ b[MAG_W-1] ^ d[MAG_W-1];
    a_d.zero   = (a == '0) || (b == '0);
    a_d.md     = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    if (fire) begin
      a_d.seg.modif = 1'b1;
      if (IS_Y) begin
        if (IS_END) a_d.seg.y1 = bound;
        else        a_d.seg.y0 = bound;
      end else begin
        if (IS_END) a_d.seg.x1 = bound;
        else        a_d.seg.x0 = bound;
      end
    end
  end

  // Stage M: product of the magnitudes.
  div_t              m_q;
  logic [PROD_W-1:0] prod_q;
  logic              m_valid_q;

  // Stage C: early overflow test on the high product bits, seed the cells.
  div_t c_d, c_q;
  logic c_valid_q;

  always_comb begin
    c_d        = m_q;
    c_d.ovf    = {2'b00, prod_q[PROD_W-2:QUO_W]} >= m_q.md;
    c_d.rem    = {2'b00, prod_q[PROD_W-2:QUO_W]};
    c_d.num_lo = prod_q[QUO_W-1:0];
    c_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      m_valid_q <= a_valid_q;
      c_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      m_q    <= a_q;
      prod_q <= PROD_W'(ma_q) * PROD_W'(mb_q);
      c_q    <= c_d;
    end
  end

  // Divider cells, most significant quotient bit first.
  logic cell_valid [QUO_W+1];
  div_t cell_data  [QUO_W+1];

  assign cell_valid[0] = c_valid_q;
  assign cell_data[0]  = c_q;

  for (genvar g = 0; g < QUO_W; g++) begin : g_cell
    lswc_div_cell #(
      .BIT_IDX(QUO_W - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(cell_valid[g]),
      .data_i (cell_data[g]),
      .valid_o(cell_valid[g+1]),
      .data_o (cell_data[g+1])
    );
  end

  // Stage F: signed add with saturation, write back the moved coordinate.
  div_t                      f;
  logic [QUO_W-1:0]          q;
  logic signed [QUO_W:0]     qs;
  logic signed [QUO_W:0]     sum;
  logic signed [COORD_W-1:0] res;
  seg_t                      f_d, f_q;
  logic                      f_valid_q;

  localparam logic signed [QUO_W:0] S_MAX = (QUO_W+1)'(32'sh7FFF_FFFF);
  localparam logic signed [QUO_W:0] S_MIN = -(QUO_W+1)'(33'sh0_8000_0000);
  localparam logic [QUO_W-1:0]      Q_LIM = QUO_W'(1) << (QUO_W - 1);

  always_comb begin
    f   = cell_data[QUO_W];
    q   = f.zero ? '0 : f.quo;
    qs  = {1'b0, q};
    sum = (QUO_W+1)'(f.other) + (f.neg ? -qs : qs);
    if (!f.zero && (f.ovf || q > Q_LIM)) begin
      res = f.neg ? COORD_W'(S_MIN) : COORD_W'(S_MAX);
    end else if (sum > S_MAX) begin
      res = COORD_W'(S_MAX);
    end else if (sum < S_MIN) begin
      res = COORD_W'(S_MIN);
    end else begin
      res = sum[COORD_W-1:0];
    end
    f_d = f.seg;
    if (f.interp) begin
      if (IS_Y) begin
        if (IS_END) f_d.x1 = res;
        else        f_d.x0 = res;
      end else begin
        if (IS_END) f_d.y1 = res;
        else        f_d.y0 = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= cell_valid[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign valid_o = f_valid_q;
  assign seg_o   = f_q;

endmodule

/* rtl/core/line_segment_window_clip_top.sv */
// Top level of the line segment window clipper: config registers and check chain.
//
//  Channel   Direction  Payload
//  s_axis    in         start_x, start_y, end_x, end_y (32 bits each)
//  m_axis    out        clipped_start_x/y, clipped_end_x/y, was_modified
//  cfg       in         win_south, win_north, win_west, win_east
//
// One segment enters per cycle while the output is not stalled. Each of the
// eight boundary checks is a pipeline of compare and clamp, a product
// register, an overflow test, a row of 34 division cells that resolve one
// quotient bit each, and the interpolating add. Reset clears only the valid
// bits and loads the window defaults. When the output transfer stalls, the
// whole chain holds; the final check's register is the output register.
module line_segment_window_clip_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // clipped_start_x [31:0], clipped_start_y [63:32], clipped_end_x [95:64],
  // clipped_end_y [127:96], was_modified [128], zeros [135:129]
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import lswc_pkg::*;

  // Window registers. The user must change them only while the chain is empty;
  // the block itself does not enforce it. Every check reads them directly.
  win_t win_q, win_d;

  always_comb begin
    win_d = win_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOUTH: win_d.south = cfg_data_i;
        CFG_NORTH: win_d.north = cfg_data_i;
        CFG_WEST:  win_d.west  = cfg_data_i;
        CFG_EAST:  win_d.east  = cfg_data_i;
        default:   win_d = win_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.south <= 32'sd0;
      win_q.north <= 32'sd50266112;
      win_q.west  <= 32'sd0;
      win_q.east  <= 32'sd67043328;
    end else begin
      win_q <= win_d;
    end
  end

  // The chain advances whenever the output register is free or being taken.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic chk_valid [NUM_CHECKS+1];
  seg_t chk_seg   [NUM_CHECKS+1];

  assign chk_valid[0]     = s_axis_tvalid;
  assign chk_seg[0].x0    = s_axis_tdata[31:0];
  assign chk_seg[0].y0    = s_axis_tdata[63:32];
  assign chk_seg[0].x1    = s_axis_tdata[95:64];
  assign chk_seg[0].y1    = s_axis_tdata[127:96];
  assign chk_seg[0].modif = 1'b0;

  // Checks in order: start x west/east, end x west/east, start y
  // south/north, end y south/north.
  for (genvar k = 0; k < NUM_CHECKS; k++) begin : g_check
    lswc_check #(
      .CHECK_IDX(k)
    ) u_check (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .win_i  (win_q),
      .valid_i(chk_valid[k]),
      .seg_i  (chk_seg[k]),
      .valid_o(chk_valid[k+1]),
      .seg_o  (chk_seg[k+1])
    );
  end

  assign m_axis_tvalid = chk_valid[NUM_CHECKS];
  assign m_axis_tdata  = {7'b0, chk_seg[NUM_CHECKS].modif, chk_seg[NUM_CHECKS].y1,
                          chk_seg[NUM_CHECKS].x1, chk_seg[NUM_CHECKS].y0,
                          chk_seg[NUM_CHECKS].x0};

endmodule

/* test/line_segment_window_clip_top_tb.sv */
// Self-checking testbench for the line segment window clipper.
module line_segment_window_clip_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lswc_pkg::*;

  // Pipeline depth, and a drain wait with a margin beyond it.
  localparam int unsigned PIPE_DEPTH = 304;
  localparam int unsigned DRAIN_CYCLES = PIPE_DEPTH + 50;
  localparam int unsigned RANDOM_SEGMENTS = 1900;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y1;
    coord_t x1;
    coord_t y0;
    coord_t x0;
  } segment_t;

  typedef struct packed {
    logic   modified;
    coord_t y1;
    coord_t x1;
    coord_t y0;
    coord_t x0;
  } clipped_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96]
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // clipped_start_x [31:0], clipped_start_y [63:32], clipped_end_x [95:64],
  // clipped_end_y [127:96], was_modified [128], zeros [135:129]
  logic [135:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  line_segment_window_clip_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // The testbench's own copy of the window registers.
  longint win_south_q, win_north_q, win_west_q, win_east_q;

  segment_t pending_segments[$];
  clipped_t expected_clips[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  longint      cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Moves the other coordinate along the segment to the bound, with the
  // quotient truncated toward zero and the sum saturated to 32 bits.
  function automatic longint interpolate(longint other, longint far_other, longint c,
                                         longint far_c, longint bound);
    longint a, b, d, s;
    logic neg;
    logic [63:0] ma, mb, md, q;
    a = bound - c;
    b = far_other - other;
    d = far_c - c;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    md = (d < 0) ? -d : d;
    q = (ma * mb) / md;
    if (a == 0 || b == 0) q = 0;
    if (q > 64'h2_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
    s = neg ? other - longint'(q) : other + longint'(q);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic clipped_t clip_segment(segment_t seg);
    longint x0, y0, x1, y1;
    logic mod;
    clipped_t r;
    x0 = seg.x0; y0 = seg.y0; x1 = seg.x1; y1 = seg.y1;
    mod = 1'b0;
    // The checks run in a fixed order, each on the values left by the ones before.
    if (x0 < win_west_q) begin
      if (x1 != x0) y0 = interpolate(y0, y1, x0, x1, win_west_q);
      x0 = win_west_q; mod = 1'b1;
    end
    if (x0 > win_east_q) begin
      if (x1 != x0) y0 = interpolate(y0, y1, x0, x1, win_east_q);
      x0 = win_east_q; mod = 1'b1;
    end
    if (x1 < win_west_q) begin
      if (x1 != x0) y1 = interpolate(y1, y0, x1, x0, win_west_q);
      x1 = win_west_q; mod = 1'b1;
    end
    if (x1 > win_east_q) begin
      if (x1 != x0) y1 = interpolate(y1, y0, x1, x0, win_east_q);
      x1 = win_east_q; mod = 1'b1;
    end
    if (y0 < win_south_q) begin
      if (y1 != y0) x0 = interpolate(x0, x1, y0, y1, win_south_q);
      y0 = win_south_q; mod = 1'b1;
    end
    if (y0 > win_north_q) begin
      if (y1 != y0) x0 = interpolate(x0, x1, y0, y1, win_north_q);
      y0 = win_north_q; mod = 1'b1;
    end
    if (y1 < win_south_q) begin
      if (y1 != y0) x1 = interpolate(x1, x0, y1, y0, win_south_q);
      y1 = win_south_q; mod = 1'b1;
    end
    if (y1 > win_north_q) begin
      if (y1 != y0) x1 = interpolate(x1, x0, y1, y0, win_north_q);
      y1 = win_north_q; mod = 1'b1;
    end
    r.x0 = x0[31:0]; r.y0 = y0[31:0]; r.x1 = x1[31:0]; r.y1 = y1[31:0];
    r.modified = mod;
    return r;
  endfunction

  // Sender: feeds queued segments, idling at the phase's rate. The expected
  // clip is computed at the accepting edge with the window then in force.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_clips.push_back(clip_segment(segment_t'(s_axis_tdata)));
        void'(pending_segments.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        // Head of queue is the next segment once the accepted one is popped.
        if (pending_segments.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_segments[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at the phase's rate and checks each transfer in order.
  always @(posedge clk_i or negedge rst_ni) begin
    clipped_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = clipped_t'(m_axis_tdata[128:0]);
        if (expected_clips.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_clips.pop_front();
          if (got !== want || m_axis_tdata[135:129] !== '0) begin
            $display("%0t: mismatch expected x0=%h y0=%h x1=%h y1=%h mod=%b",
                     $time, want.x0, want.y0, want.x1, want.y1, want.modified);
            $display("%0t:          actual   x0=%h y0=%h x1=%h y1=%h mod=%b pad=%h",
                     $time, got.x0, got.y0, got.x1, got.y1, got.modified,
                     m_axis_tdata[135:129]);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Writes one window register while the clipper is idle.
  task automatic write_window(logic [1:0] idx, coord_t value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SOUTH: win_south_q = value;
      CFG_NORTH: win_north_q = value;
      CFG_WEST:  win_west_q  = value;
      CFG_EAST:  win_east_q  = value;
      default: ;
    endcase
  endtask

  task automatic set_window(coord_t south, coord_t north, coord_t west, coord_t east);
    write_window(CFG_SOUTH, south);
    write_window(CFG_NORTH, north);
    write_window(CFG_WEST, west);
    write_window(CFG_EAST, east);
  endtask

  // Waits until every queued segment is sent and every clip has come back.
  task automatic drain();
    while (pending_segments.size() != 0 || s_axis_tvalid || expected_clips.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic coord_t random_coord(coord_t lo, coord_t hi);
    int unsigned pick;
    longint span;
    pick = $urandom_range(9);
    span = longint'(hi) - longint'(lo);
    if (pick == 0) return coord_t'($urandom());
    if (pick == 1) return (($urandom_range(1) == 1) ? lo : hi);
    // Mostly near the window, sometimes well outside it.
    return coord_t'(longint'(lo) - span / 2 + (longint'($urandom()) % (2 * span + 1)));
  endfunction

  task automatic queue_random(int unsigned count);
    segment_t seg;
    for (int unsigned i = 0; i < count; i++) begin
      seg.x0 = random_coord(coord_t'(win_west_q), coord_t'(win_east_q));
      seg.y0 = random_coord(coord_t'(win_south_q), coord_t'(win_north_q));
      seg.x1 = ($urandom_range(7) == 0) ? seg.x0 :
               random_coord(coord_t'(win_west_q), coord_t'(win_east_q));
      seg.y1 = ($urandom_range(7) == 0) ? seg.y0 :
               random_coord(coord_t'(win_south_q), coord_t'(win_north_q));
      pending_segments.push_back(seg);
    end
  endtask

  task automatic queue_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    segment_t seg;
    seg.x0 = x0; seg.y0 = y0; seg.x1 = x1; seg.y1 = y1;
    pending_segments.push_back(seg);
  endtask

  initial begin
    coord_t cmin, cmax;
    cmin = 32'sh8000_0000;
    cmax = 32'sh7FFF_FFFF;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SOUTH;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    cycle_count = 0;
    win_south_q = 0;
    win_north_q = 50266112;
    win_west_q = 0;
    win_east_q = 67043328;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed segments with the reset window: inside, crossing, vertical and
    // horizontal (equal compared coordinates), extremes that overflow.
    queue_segment(32'sh0001_0000, 32'sh0001_0000, 32'sh0010_0000, 32'sh0020_0000);
    queue_segment(-32'sh0010_0000, 32'sh0100_0000, 32'sh0500_0000, 32'sh0200_0000);
    queue_segment(32'sh0500_0000, -32'sh0010_0000, 32'sh0500_0000, 32'sh0400_0000);
    queue_segment(-32'sh0010_0000, 32'sh0100_0000, 32'sh0600_0000, 32'sh0100_0000);
    queue_segment(cmin, cmin, cmax, cmax);
    queue_segment(cmax, cmin, cmin, cmax);
    queue_segment(cmin, cmax, cmin + 1, cmin);
    queue_segment(cmax, cmax, cmax, cmax);
    queue_segment(cmin, cmin, cmin, cmin);
    queue_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh03FF_0000, 32'sh02FF_0000);
    queue_segment(32'sh0000_0000, 32'sh0000_0000, -1, -1);
    queue_segment(cmin, 32'sh0000_0001, cmax, 32'sh7FFF_0000);
    queue_segment(32'sh7000_0000, 32'sh8000_0001, 32'sh7000_0001, 32'sh7FFF_FFFE);
    queue_segment(32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'h5555_5555, 32'shFFFF_FFFF);
    drain();

    // Window at the extremes of the register range, then an inverted one, then a narrow one.
    set_window(cmin, cmax, cmin, cmax);
    queue_segment(cmin, cmin, cmax, cmax);
    queue_segment(32'sh1234_5678, 32'shDEAD_BEEF, 32'shCAFE_F00D, 32'sh0BAD_F00D);
    queue_random(60);
    drain();
    set_window(32'sh0100_0000, -32'sh0100_0000, 32'sh0200_0000, -32'sh0200_0000);
    queue_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0300_0000, 32'sh0300_0000);
    queue_segment(cmin, cmax, cmax, cmin);
    queue_random(60);
    drain();
    set_window(cmax - 1, cmax, cmin, cmin + 1);
    queue_random(60);
    drain();

    // Random segments across the idling phases and several windows.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (phase == 4)
        set_window(0, 50266112, 0, 67043328);
      else if (phase > 0)
        set_window(coord_t'($urandom_range(32'h0100_0000) - 32'h0080_0000),
                   coord_t'($urandom_range(32'h0800_0000) + 32'h0100_0000),
                   coord_t'($urandom_range(32'h0100_0000) - 32'h0080_0000),
                   coord_t'($urandom_range(32'h0800_0000) + 32'h0100_0000));
      queue_random((RANDOM_SEGMENTS - 180) / 8);
      drain();
    end

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lswc_pkg.sv
rtl/core/lswc_div_cell.sv
rtl/core/lswc_check.sv
rtl/core/line_segment_window_clip_top.sv
test/line_segment_window_clip_top_tb.sv
